// ----- hw/rtl/md5g_pkg.sv -----
// Shared types and constants for the MD5 name-based GUID generator.
// No dependencies.
package md5g_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } md5g_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_RUN,
    ST_OUT
  } md5g_state_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [7:0]  VER_MASK = 8'h0F;
  localparam logic [7:0]  VER_BITS = 8'h30;
  localparam logic [7:0]  VAR_MASK = 8'h3F;
  localparam logic [7:0]  VAR_BITS = 8'h80;
  localparam logic [7:0]  PREFIX_4 = 8'hDA;
  localparam logic [7:0]  PREFIX_5 = 8'hE0;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    unique case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/md5_name_guid_generator_unit.sv -----
// Top level of the MD5 name-based GUID generator, built from md5g_pkg, md5g_fifo and
// md5g_engine. Each input beat carries one byte in s_tdata; s_tuser says that the byte
// belongs to the message and s_tlast ends the message, so a beat with s_tuser low and
// s_tlast high ends a message as it stands, even an empty one. One GUID beat comes out
// per message, guid_upper in m_tdata[63:0] and guid_lower in m_tdata[127:64], and the
// block then returns to the initial MD5 state. The engine takes one byte per cycle while
// idle; the 64th byte of each block starts the 64 rounds, during which no byte is taken.
// After the last beat, the engine writes the padding bytes up to byte 56 of the block,
// then the length, runs the 64 rounds and loads the output register; with p bytes of
// the last block filled and p of 56 or more, one more block is compressed first. A
// two-beat queue at the input registers each beat and lets the sender run ahead
// during the rounds. A finished GUID waits in the output register until it is taken;
// only the next GUID waits for it.
module md5_name_guid_generator_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // has_byte
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // guid_upper, guid_lower
);
  import md5g_pkg::*;
  md5g_item_t qi, qo;
  logic qv, qr;
  logic [63:0] up, lo;
  assign qi = '{data_byte: s_tdata, has_byte: s_tuser, last: s_tlast};
  md5g_fifo u_q (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_item(qi),
                 .out_valid(qv), .out_ready(qr), .out_item(qo));
  md5g_engine u_e (.clk, .rst, .item_valid(qv), .item_ready(qr), .item(qo),
                   .res_valid(m_tvalid), .res_ready(m_tready),
                   .guid_upper(up), .guid_lower(lo));
  assign m_tdata = {lo, up};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
  a_out_reset: assert property (@(posedge clk) rst |=> !m_tvalid);
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown(m_tdata));
  a_in_ready_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(s_tready));
endmodule

// ----- hw/rtl/md5g_fifo.sv -----
// Short item queue between the input side and the hashing engine.
// Depends on md5g_pkg.
module md5g_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  md5g_pkg::md5g_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output md5g_pkg::md5g_item_t out_item
);
  import md5g_pkg::*;

  md5g_item_t slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slot[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + 2'((in_valid && in_ready) ? 1 : 0)
                     - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end
endmodule

// ----- hw/rtl/md5g_engine.sv -----
// MD5 engine: block buffer, padding sequencer, one round per cycle, GUID output register.
// Depends on md5g_pkg.
module md5g_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  md5g_pkg::md5g_item_t item,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [63:0]       guid_upper,
  output logic [63:0]       guid_lower
);
  import md5g_pkg::*;

  md5g_state_t state, state_next;
  logic [31:0] blk [16];
  logic [31:0] h [4];
  logic [31:0] a, b, c, d;
  logic [63:0] bit_count;
  logic [5:0]  pos;        // next free byte within the block
  logic [5:0]  ppos;       // next padding byte within the block
  logic        pad_first;  // the 0x80 marker is still to be written
  logic [5:0]  rnd;
  logic        finishing;  // the running compression belongs to the padding
  logic        len_done;   // the running compression holds the length

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic        start_run;
  logic        emit;

  logic [31:0] f, s, sum, rot;
  logic [3:0]  g;
  logic [31:0] n0, n1, n2, n3;
  logic [7:0]  dg [16];

  assign pos = bit_count[8:3];

  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = rnd[3:0];
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = 4'(5 * rnd + 1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'(3 * rnd + 5);
      end
      2'd3: begin
        f = c ^ (b | ~d);
        g = 4'(7 * rnd);
      end
    endcase
    sum = a + f + sine_k(rnd) + blk[g];
    s   = sum;
    rot = (s << rot_amt(rnd)) | (s >> (6'd32 - {1'b0, rot_amt(rnd)}));
  end

  assign n0 = h[0] + d;
  assign n1 = h[1] + b + rot;
  assign n2 = h[2] + b;
  assign n3 = h[3] + c;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    wr_en      = 1'b0;
    wr_pos     = pos;
    wr_byte    = item.data_byte;
    start_run  = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          wr_en = item.has_byte;
          // A byte that fills the block is compressed before any padding.
          if (item.has_byte && pos == 6'd63) begin
            start_run  = 1'b1;
            state_next = ST_RUN;
          end else if (item.last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_pos  = ppos;
        wr_byte = pad_first ? PAD_BYTE : 8'h00;
        if (ppos == 6'd55) begin
          state_next = ST_LEN;
        end else if (ppos == 6'd63) begin
          start_run  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_LEN: begin
        start_run  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (rnd == 6'd63) begin
          if (len_done)       state_next = ST_OUT;
          else if (finishing) state_next = ST_PAD;
          else                state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!res_valid || res_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= '0;
      h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT;
      finishing <= 1'b0;
      len_done  <= 1'b0;
      pad_first <= 1'b0;
      ppos      <= '0;
      rnd       <= '0;
    end else begin
      if (wr_en) blk[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
      if (start_run) begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; rnd <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.has_byte) bit_count <= bit_count + 64'd8;
            finishing <= item.last;
            len_done  <= 1'b0;
            pad_first <= 1'b1;
            ppos      <= item.has_byte ? 6'(pos + 6'd1) : pos;
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          ppos      <= ppos + 6'd1;
        end
        ST_LEN: begin
          blk[14]  <= bit_count[31:0];
          blk[15]  <= bit_count[63:32];
          len_done <= 1'b1;
        end
        ST_RUN: begin
          a <= d; d <= c; c <= b; b <= b + rot;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            h[0] <= n0; h[1] <= n1; h[2] <= n2; h[3] <= n3;
          end
        end
        ST_OUT: begin
          if (emit) begin
            guid_upper <= {dg[0], dg[1], dg[2], dg[3], PREFIX_4, PREFIX_5,
                           (dg[6] & VER_MASK) | VER_BITS, dg[7]};
            guid_lower <= {(dg[8] & VAR_MASK) | VAR_BITS, dg[9], dg[10], dg[11],
                           dg[12], dg[13], dg[14], dg[15]};
            h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT;
            bit_count <= '0;
            finishing <= 1'b0;
            len_done  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // The result register holds its beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst)            res_valid <= 1'b0;
    else if (emit)      res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) dg[i] = h[i >> 2][8 * (i & 3) +: 8];
  end
endmodule
